// ===== rtl/ppe_pkg.sv =====
// ppe_pkg: shared constants, codes, slot entry layout and saturation helpers
// for the particle pool engine; no dependencies
`default_nettype none
package ppe_pkg;

  localparam int POOL_SIZE = 32;
  localparam int SLOT_W    = 5;
  localparam int CNT_W     = 6;
  localparam int NUM_W     = 26;
  localparam int DEN_W     = 17;
  localparam int QUO_W     = 16;

  typedef enum logic [1:0] {
    FN_EMIT  = 2'd0,
    FN_TICK  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REC_ACK  = 2'd0,
    REC_LIVE = 2'd1,
    REC_END  = 2'd2
  } rec_t;

  localparam logic [1:0] KIND_FIRE  = 2'd0;
  localparam logic [1:0] KIND_SMOKE = 2'd1;
  localparam logic [1:0] KIND_BLOOD = 2'd2;

  localparam logic signed [35:0] FLOOR_OFS = 36'sd13;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [15:0]        life_left;
    logic [15:0]        life_start;
    logic [15:0]        size;
    logic [31:0]        color;
    logic [1:0]         kind;
  } entry_t;

  function automatic logic signed [35:0] sx36(input logic signed [15:0] v);
    return {{20{v[15]}}, v};
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -36'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [15:0] satu16(input logic [32:0] v);
    return (v > 33'd65535) ? 16'hffff : v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ppe_if.sv =====
// ppe_if: valid/ready channel interfaces for the particle pool engine
// input item, result item and configuration write; no dependencies
`default_nettype none
interface ppe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic [15:0]        lifetime;
  logic [15:0]        start_size;
  logic [31:0]        color_rgba;
  logic [1:0]         kind;
  logic [15:0]        delta_time;
  modport source (output valid, func, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  lifetime, start_size, color_rgba, kind, delta_time, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                lifetime, start_size, color_rgba, kind, delta_time, output ready);
endinterface

interface ppe_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record;
  logic [4:0]         slot;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic [15:0]        out_size;
  logic [31:0]        out_color;
  logic [1:0]         out_kind;
  logic               last;
  modport source (output valid, record, slot, out_x, out_y, out_z, out_size,
                  out_color, out_kind, last, input ready);
  modport sink (input valid, record, slot, out_x, out_y, out_z, out_size,
                out_color, out_kind, last, output ready);
endinterface

interface ppe_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] floor_height;
  modport source (output valid, floor_height, input ready);
  modport sink (input valid, floor_height, output ready);
endinterface
`default_nettype wire

// ===== rtl/ppe_ram.sv =====
// ppe_ram: generic simple dual-port memory, one write and one registered read
// no dependencies
`default_nettype none
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ppe_div.sv =====
// ppe_div: restoring divider, one quotient bit per cycle
// depends on ppe_pkg
`default_nettype none
module ppe_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ppe_pkg::NUM_W-1:0] num,
  input  wire logic [ppe_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic      [ppe_pkg::QUO_W-1:0] quo
);
  import ppe_pkg::*;

  localparam int TW = DEN_W + QUO_W;

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [$clog2(QUO_W)-1:0]  k_r, k_nxt;
  logic [NUM_W-1:0]          rem_r, rem_nxt;
  logic [DEN_W-1:0]          den_r, den_nxt;
  logic [QUO_W-1:0]          quo_r, quo_nxt;
  logic [TW-1:0]             trial;
  logic                      fits;

  assign trial = {{QUO_W{1'b0}}, den_r} << k_r;
  assign fits  = {{(TW-NUM_W){1'b0}}, rem_r} >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = '1;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt     = rem_r - trial[NUM_W-1:0];
        quo_nxt[k_r] = 1'b1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== rtl/particle_pool_engine.sv =====
// particle_pool_engine: one item at a time. emit: acknowledge after the item is
// taken, or after the least-life sweep reads all 32 slots when the pool is full.
// tick: inactive slots are skipped and expiring slots are dropped; a live fire slot
// runs three colour ratios, a smoke or blood slot one and other kinds none, all on
// the shared 16-step divider; then the end record.
// reset clears the active mask, slot count, floor and the output valid flag;
// slot memory contents stay undefined until written, no clearing pass
`default_nettype none
module particle_pool_engine (
  input wire logic clk,
  input wire logic rst_n,
  ppe_in_if.sink   in_ch,
  ppe_out_if.source out_ch,
  ppe_cfg_if.sink  cfg_ch
);
  import ppe_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SWEEP  = 11'b00000000010,
    S_ACK    = 11'b00000000100,
    S_TNEXT  = 11'b00000001000,
    S_RD     = 11'b00000010000,
    S_MUL    = 11'b00000100000,
    S_ACC    = 11'b00001000000,
    S_DIV    = 11'b00010000000,
    S_DIVW   = 11'b00100000000,
    S_WB     = 11'b01000000000,
    S_REPORT = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    DV_G = 2'd0,
    DV_B = 2'd1,
    DV_A = 2'd2
  } dsel_t;

  typedef struct packed {
    logic [1:0]         record;
    logic [SLOT_W-1:0]  slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        size;
    logic [31:0]        color;
    logic [1:0]         kind;
    logic               last;
  } result_t;

  state_t                state_r, state_nxt;
  logic                  end_pend_r, end_pend_nxt;
  logic [POOL_SIZE-1:0]  mask_r, mask_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic signed [15:0]    floor_r;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      sw_r, sw_nxt;
  logic                  pv_r, pv_nxt;
  logic [SLOT_W-1:0]     pidx_r, pidx_nxt;
  logic [16:0]           best_r, best_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  entry_t                em_r, em_nxt;
  entry_t                w_r, w_nxt;
  logic [15:0]           d_r, d_nxt;
  logic [1:0]            m_r, m_nxt;
  logic signed [33:0]    prod_r, prod_nxt;
  dsel_t                 dsel_r, dsel_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_r, out_nxt;
  logic [17:0]           fpre_r, fpre_nxt;
  logic [15:0]           fall_r, fall_nxt;
  logic [33:0]           fall_prod;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                rd_ent, ent_wb;

  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic [QUO_W-1:0]      div_quo;
  logic [7:0]            cbyte;

  logic                  out_free;
  logic                  fs_found;
  logic [SLOT_W-1:0]     fs_idx;
  logic [POOL_SIZE-1:0]  used_lim;

  logic signed [16:0]    op_a;
  logic signed [33:0]    rsh;
  logic signed [15:0]    pos_sel;
  logic signed [15:0]    pos_new;
  logic [32:0]           sz_inc;
  logic [15:0]           sz_new;
  logic [15:0]           s_eff;
  logic [NUM_W-1:0]      l26, s26;
  logic [17:0]           vy_inc;
  logic signed [15:0]    thr;

  assign rd_ent = entry_t'(ram_rdata);
  assign out_free = !out_valid_r || out_ch.ready;

  ppe_ram #(.WIDTH($bits(entry_t)), .DEPTH(POOL_SIZE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_we && state_r == S_ACK ? em_r : ent_wb),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // first free slot below the fill count
  always_comb begin
    fs_found = 1'b0;
    fs_idx   = '0;
    for (int k = POOL_SIZE - 1; k >= 0; k--) begin
      used_lim[k] = CNT_W'(k) < used_r;
      if (!mask_r[k] && used_lim[k]) begin
        fs_found = 1'b1;
        fs_idx   = SLOT_W'(k);
      end
    end
  end

  // integration datapath
  always_comb begin
    case (m_r)
      2'd0: begin
        op_a    = {w_r.vel_x[15], w_r.vel_x};
        pos_sel = w_r.pos_x;
      end
      2'd1: begin
        op_a    = {w_r.vel_y[15], w_r.vel_y};
        pos_sel = w_r.pos_y;
      end
      2'd2: begin
        op_a    = {w_r.vel_z[15], w_r.vel_z};
        pos_sel = w_r.pos_z;
      end
      default: begin
        op_a    = $signed({1'b0, w_r.size});
        pos_sel = w_r.pos_z;
      end
    endcase
  end

  assign rsh     = (prod_r + 34'sd2048) >>> 12;
  assign pos_new = sat16(sx36(pos_sel) + {{2{rsh[33]}}, rsh});
  assign sz_inc  = (w_r.kind == KIND_FIRE) ?
                   (({1'b0, prod_r[31:0]} + 33'd4096) >> 13) :
                   (({1'b0, prod_r[31:0]} + 33'd2048) >> 12);
  assign sz_new  = satu16({17'd0, w_r.size} + sz_inc);

  // blood fall, (49d + 40) / 80 as ((49d + 40) >> 4) / 5 by reciprocal multiply
  assign fpre_nxt  = 18'(({6'd0, d_r} * 22'd49 + 22'd40) >> 4);
  assign fall_prod = {16'd0, fpre_r} * 34'd52429;
  assign fall_nxt  = fall_prod[33:18];

  // colour ratio operands
  assign s_eff = (w_r.life_start == 16'd0) ? 16'd1 : w_r.life_start;
  assign l26   = {10'd0, w_r.life_left};
  assign s26   = {10'd0, s_eff};
  assign div_den = {s_eff, 1'b0};

  always_comb begin
    case (dsel_r)
      DV_G: div_num = l26 * 26'd357 + s26 * 26'd153 + s26;
      DV_B: div_num = l26 * 26'd51 + s26;
      default: begin
        case (w_r.kind)
          KIND_FIRE:  div_num = l26 * 26'd408 + s26;
          KIND_SMOKE: div_num = l26 * 26'd204 + s26;
          default:    div_num = l26 * 26'd459 + s26;
        endcase
      end
    endcase
  end

  assign cbyte = (|div_quo[15:8]) ? 8'hff : div_quo[7:0];

  // per-kind write-back
  assign vy_inc = (w_r.kind == KIND_FIRE) ? (({2'b0, d_r} * 18'd3 + 18'd16) >> 5) :
                                            (({2'b0, d_r} + 18'd16) >> 5);
  assign thr    = sat16(sx36(floor_r) + FLOOR_OFS);

  always_comb begin
    ent_wb = w_r;
    case (w_r.kind)
      KIND_FIRE: begin
        ent_wb.vel_y        = sat16(sx36(w_r.vel_y) + {18'd0, vy_inc});
        ent_wb.color[31:24] = 8'hff;
      end
      KIND_SMOKE: begin
        ent_wb.vel_y = sat16(sx36(w_r.vel_y) + {18'd0, vy_inc});
      end
      KIND_BLOOD: begin
        if (w_r.pos_y < thr) begin
          ent_wb.pos_y     = thr;
          ent_wb.vel_x     = '0;
          ent_wb.vel_y     = '0;
          ent_wb.vel_z     = '0;
          ent_wb.life_left = ({1'b0, w_r.life_left} > {d_r, 1'b0}) ?
                             16'(w_r.life_left - {d_r[14:0], 1'b0}) : 16'd0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    end_pend_nxt  = end_pend_r;
    mask_nxt      = mask_r;
    used_nxt      = used_r;
    i_nxt         = i_r;
    sw_nxt        = sw_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    best_nxt      = best_r;
    slot_nxt      = slot_r;
    em_nxt        = em_r;
    w_nxt         = w_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    prod_nxt      = prod_r;
    dsel_nxt      = dsel_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_we        = 1'b0;
    ram_waddr     = i_r[SLOT_W-1:0];
    ram_raddr     = i_r[SLOT_W-1:0];
    div_start     = 1'b0;
    in_ch.ready   = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = !end_pend_r;
        if (end_pend_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.record = REC_END;
            out_nxt.last   = 1'b1;
            end_pend_nxt  = 1'b0;
          end
        end else if (in_ch.valid) begin
          em_nxt.pos_x      = in_ch.pos_x;
          em_nxt.pos_y      = in_ch.pos_y;
          em_nxt.pos_z      = in_ch.pos_z;
          em_nxt.vel_x      = in_ch.vel_x;
          em_nxt.vel_y      = in_ch.vel_y;
          em_nxt.vel_z      = in_ch.vel_z;
          em_nxt.life_left  = in_ch.lifetime;
          em_nxt.life_start = in_ch.lifetime;
          em_nxt.size       = in_ch.start_size;
          em_nxt.color      = in_ch.color_rgba;
          em_nxt.kind       = in_ch.kind;
          d_nxt             = in_ch.delta_time;
          case (func_t'(in_ch.func))
            FN_EMIT: begin
              if (fs_found) begin
                slot_nxt  = fs_idx;
                state_nxt = S_ACK;
              end else if (used_r < CNT_W'(POOL_SIZE)) begin
                slot_nxt  = used_r[SLOT_W-1:0];
                used_nxt  = used_r + 1'b1;
                state_nxt = S_ACK;
              end else begin
                sw_nxt    = '0;
                pv_nxt    = 1'b0;
                best_nxt  = 17'h10000;
                slot_nxt  = '0;
                state_nxt = S_SWEEP;
              end
            end
            FN_TICK: begin
              i_nxt     = '0;
              state_nxt = S_TNEXT;
            end
            FN_CLEAR: begin
              mask_nxt = '0;
              used_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        ram_raddr = sw_r[SLOT_W-1:0];
        if (sw_r < CNT_W'(POOL_SIZE)) begin
          sw_nxt   = sw_r + 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = sw_r[SLOT_W-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if ({1'b0, rd_ent.life_left} < best_r) begin
            best_nxt = {1'b0, rd_ent.life_left};
            slot_nxt = pidx_r;
          end
          if (pidx_r == SLOT_W'(POOL_SIZE - 1)) begin
            state_nxt = S_ACK;
          end
        end
      end
      S_ACK: begin
        if (out_free) begin
          ram_we           = 1'b1;
          ram_waddr        = slot_r;
          mask_nxt[slot_r] = 1'b1;
          out_valid_nxt    = 1'b1;
          out_nxt.record   = REC_ACK;
          out_nxt.slot     = slot_r;
          out_nxt.x        = em_r.pos_x;
          out_nxt.y        = em_r.pos_y;
          out_nxt.z        = em_r.pos_z;
          out_nxt.size     = em_r.size;
          out_nxt.color    = em_r.color;
          out_nxt.kind     = em_r.kind;
          out_nxt.last     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_TNEXT: begin
        if (i_r >= used_r) begin
          end_pend_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else if (mask_r[i_r[SLOT_W-1:0]]) begin
          state_nxt = S_RD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_RD: begin
        w_nxt = rd_ent;
        if (rd_ent.life_left > d_r) begin
          w_nxt.life_left = rd_ent.life_left - d_r;
          m_nxt           = '0;
          state_nxt       = S_MUL;
        end else begin
          mask_nxt[i_r[SLOT_W-1:0]] = 1'b0;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_TNEXT;
        end
      end
      S_MUL: begin
        prod_nxt  = op_a * $signed({1'b0, d_r});
        state_nxt = S_ACC;
      end
      S_ACC: begin
        case (m_r)
          2'd0: w_nxt.pos_x = pos_new;
          2'd1: w_nxt.pos_y = pos_new;
          2'd2: w_nxt.pos_z = pos_new;
          default: begin
            if (w_r.kind == KIND_FIRE || w_r.kind == KIND_SMOKE) begin
              w_nxt.size = sz_new;
            end
          end
        endcase
        if (m_r == 2'd3) begin
          case (w_r.kind)
            KIND_FIRE: begin
              dsel_nxt  = DV_G;
              state_nxt = S_DIV;
            end
            KIND_SMOKE: begin
              dsel_nxt  = DV_A;
              state_nxt = S_DIV;
            end
            KIND_BLOOD: begin
              w_nxt.vel_y = sat16(sx36(w_r.vel_y) - {20'd0, fall_r});
              dsel_nxt    = DV_A;
              state_nxt   = S_DIV;
            end
            default: state_nxt = S_WB;
          endcase
        end else begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          case (dsel_r)
            DV_G: begin
              w_nxt.color[23:16] = cbyte;
              dsel_nxt  = DV_B;
              state_nxt = S_DIV;
            end
            DV_B: begin
              w_nxt.color[15:8] = cbyte;
              dsel_nxt  = DV_A;
              state_nxt = S_DIV;
            end
            default: begin
              w_nxt.color[7:0] = cbyte;
              state_nxt = S_WB;
            end
          endcase
        end
      end
      S_WB: begin
        ram_we    = 1'b1;
        w_nxt     = ent_wb;
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt.record = REC_LIVE;
          out_nxt.slot   = i_r[SLOT_W-1:0];
          out_nxt.x      = w_r.pos_x;
          out_nxt.y      = w_r.pos_y;
          out_nxt.z      = w_r.pos_z;
          out_nxt.size   = w_r.size;
          out_nxt.color  = w_r.color;
          out_nxt.kind   = w_r.kind;
          out_nxt.last   = 1'b0;
          i_nxt          = i_r + 1'b1;
          state_nxt      = S_TNEXT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      end_pend_r  <= 1'b0;
      mask_r      <= '0;
      used_r      <= '0;
      floor_r     <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      end_pend_r  <= end_pend_nxt;
      mask_r      <= mask_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      if (cfg_ch.valid) begin
        floor_r <= cfg_ch.floor_height;
      end
    end
    i_r    <= i_nxt;
    sw_r   <= sw_nxt;
    pidx_r <= pidx_nxt;
    best_r <= best_nxt;
    slot_r <= slot_nxt;
    em_r   <= em_nxt;
    w_r    <= w_nxt;
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    prod_r <= prod_nxt;
    dsel_r <= dsel_nxt;
    out_r  <= out_nxt;
    fpre_r <= fpre_nxt;
    fall_r <= fall_nxt;
  end

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.record    = out_r.record;
  assign out_ch.slot      = out_r.slot;
  assign out_ch.out_x     = out_r.x;
  assign out_ch.out_y     = out_r.y;
  assign out_ch.out_z     = out_r.z;
  assign out_ch.out_size  = out_r.size;
  assign out_ch.out_color = out_r.color;
  assign out_ch.out_kind  = out_r.kind;
  assign out_ch.last      = out_r.last;

  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(POOL_SIZE))
    else $error("slot count beyond pool size");

  a_mask_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r & ~used_lim) == '0)
    else $error("active slot above slot count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.func == FN_CLEAR) |=>
      (mask_r == '0 && used_r == '0))
    else $error("clear left slots active");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVW)
    else $error("divider finished outside its wait state");

endmodule
`default_nettype wire

// ===== test/tb_particle_pool_engine.sv =====
// tb_particle_pool_engine: self-checking testbench for the particle pool engine
// directed table then random emit/tick/clear/none traffic, checked against a local pool model
// depends on ppe_pkg, the channel interfaces in ppe_if and particle_pool_engine
`default_nettype none
module tb_particle_pool_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ppe_pkg::*;

  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam int         RUN_LIMIT  = 3000000;
  localparam int         N_DIR      = 17;
  localparam int         N_RAND     = 50;

  typedef struct {
    func_t              func;
    logic signed [15:0] px, py, pz, vx, vy, vz;
    logic [15:0]        life, size;
    logic [31:0]        color;
    logic [1:0]         kind;
    logic [15:0]        dt;
  } item_t;

  typedef struct {
    item_t      it;
    bit         typed;
    logic [4:0] ack_slot;
  } row_t;

  typedef struct {
    rec_t               rec;
    logic [4:0]         slot;
    logic signed [15:0] x, y, z;
    logic [15:0]        size;
    logic [31:0]        color;
    logic [1:0]         kind;
    logic               last;
  } res_t;

  logic clk;
  logic rst_n;
  ppe_in_if  in_ch();
  ppe_out_if out_ch();
  ppe_cfg_if cfg_ch();

  particle_pool_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // pool model
  int          pos_m   [32][3];
  int          vel_m   [32][3];
  int unsigned life_m  [32];
  int unsigned start_m [32];
  int unsigned size_m  [32];
  logic [31:0] color_m [32];
  logic [1:0]  kind_m  [32];
  bit   [31:0] live_mask;
  int unsigned n_used;
  int          floor_m;

  res_t pending_q[$];
  int   n_err;
  int   n_seen;
  int   cyc;
  int   burst_left;

  row_t dir_rows [N_DIR] = '{
    '{'{FN_EMIT, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh7fff, 16'sh0001,
        16'hffff, 16'hffff, 32'hffffffff, KIND_FIRE, 16'h0000}, 1'b1, 5'd0},
    '{'{FN_EMIT, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh7fff, 16'sh8000, 16'shffff,
        16'h0001, 16'h0000, 32'h00000000, KIND_SMOKE, 16'hffff}, 1'b1, 5'd1},
    '{'{FN_EMIT, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000, 16'shff00, 16'sh0000,
        16'h8000, 16'h1000, 32'h80402010, KIND_BLOOD, 16'h0000}, 1'b1, 5'd2},
    '{'{FN_EMIT, 16'sh1234, 16'sh0000, 16'sh4321, 16'sh0100, 16'sh0100, 16'sh0100,
        16'h2000, 16'h0800, 32'h12345678, KIND_OTHER, 16'h0000}, 1'b1, 5'd3},
    '{'{FN_EMIT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h1000, 32'hff0000ff, KIND_FIRE, 16'h0000}, 1'b1, 5'd4},
    '{'{FN_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'h0000}, 1'b0, 5'd0},
    '{'{FN_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'h0400}, 1'b0, 5'd0},
    '{'{FN_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'h0800}, 1'b0, 5'd0},
    '{'{FN_EMIT, 16'shff00, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0200, 16'sh0000,
        16'h4000, 16'h2000, 32'h808080c0, KIND_SMOKE, 16'h0000}, 1'b1, 5'd1},
    '{'{FN_NONE, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
        16'h5555, 16'haaaa, 32'h5555aaaa, KIND_OTHER, 16'hffff}, 1'b0, 5'd0},
    '{'{FN_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'hffff}, 1'b0, 5'd0},
    '{'{FN_CLEAR, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'h0000}, 1'b0, 5'd0},
    '{'{FN_EMIT, 16'sh0000, 16'sh0040, 16'sh0000, 16'sh0000, 16'shf000, 16'sh0000,
        16'hf000, 16'h1000, 32'hc0000080, KIND_BLOOD, 16'h0000}, 1'b1, 5'd0},
    '{'{FN_EMIT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0080, 16'sh0080, 16'shff80,
        16'hf000, 16'h1000, 32'h606060ff, KIND_SMOKE, 16'h0000}, 1'b1, 5'd1},
    '{'{FN_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'h0100}, 1'b0, 5'd0},
    '{'{FN_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'h1000}, 1'b0, 5'd0},
    '{'{FN_CLEAR, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'h0000, 16'h0000, 32'h0, KIND_FIRE, 16'h0000}, 1'b0, 5'd0}
  };

  function automatic longint sat_s16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint sat_u16(longint v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint y;
    y = v + (longint'(1) << (sh - 1));
    return y >>> sh;
  endfunction

  function automatic logic [7:0] fade_byte(longint n, longint m, longint l, longint s);
    longint q;
    if (s == 0) s = 1;
    q = (n * l + m * s + s) / (2 * s);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic res_t slot_report(rec_t rec, int i, logic last);
    res_t r;
    r.rec   = rec;
    r.slot  = i[4:0];
    r.x     = pos_m[i][0][15:0];
    r.y     = pos_m[i][1][15:0];
    r.z     = pos_m[i][2][15:0];
    r.size  = size_m[i][15:0];
    r.color = color_m[i];
    r.kind  = kind_m[i];
    r.last  = last;
    return r;
  endfunction

  function automatic void age_slot(int i, longint d);
    longint l, s, thr;
    logic [31:0] c;
    life_m[i] = (life_m[i] > d) ? life_m[i] - d : 0;
    if (life_m[i] == 0) begin
      live_mask[i] = 1'b0;
      return;
    end
    for (int a = 0; a < 3; a++) begin
      pos_m[i][a] = sat_s16(longint'(pos_m[i][a]) + round_shift(longint'(vel_m[i][a]) * d, 12));
    end
    l = life_m[i];
    s = start_m[i];
    c = color_m[i];
    case (kind_m[i])
      KIND_FIRE: begin
        vel_m[i][1] = sat_s16(longint'(vel_m[i][1]) + ((3 * d + 16) >> 5));
        c = {8'hff, fade_byte(357, 153, l, s), fade_byte(51, 0, l, s), fade_byte(408, 0, l, s)};
        size_m[i] = sat_u16(longint'(size_m[i]) + ((longint'(size_m[i]) * d + 4096) >> 13));
      end
      KIND_SMOKE: begin
        vel_m[i][1] = sat_s16(longint'(vel_m[i][1]) + ((d + 16) >> 5));
        c[7:0] = fade_byte(204, 0, l, s);
        size_m[i] = sat_u16(longint'(size_m[i]) + ((longint'(size_m[i]) * d + 2048) >> 12));
      end
      KIND_BLOOD: begin
        thr = sat_s16(longint'(floor_m) + 13);
        vel_m[i][1] = sat_s16(longint'(vel_m[i][1]) - ((49 * d + 40) / 80));
        c[7:0] = fade_byte(459, 0, l, s);
        if (pos_m[i][1] < thr) begin
          pos_m[i][1] = thr;
          vel_m[i][0] = 0;
          vel_m[i][1] = 0;
          vel_m[i][2] = 0;
          life_m[i] = (life_m[i] > 2 * d) ? life_m[i] - 2 * d : 0;
        end
      end
      default: ;
    endcase
    color_m[i] = c;
  endfunction

  function automatic void predict_pool(item_t it, bit typed, logic [4:0] typed_slot);
    int slot;
    bit found;
    int unsigned best;
    res_t r;
    case (it.func)
      FN_EMIT: begin
        slot = 0;
        found = 0;
        for (int i = 0; i < n_used; i++) begin
          if (!found && !live_mask[i]) begin
            slot = i;
            found = 1;
          end
        end
        if (!found) begin
          if (n_used < POOL_SIZE) begin
            slot = n_used;
            n_used++;
          end else begin
            best = 32'h10000;
            for (int i = 0; i < POOL_SIZE; i++) begin
              if (life_m[i] < best) begin
                best = life_m[i];
                slot = i;
              end
            end
          end
        end
        pos_m[slot][0] = int'(it.px);
        pos_m[slot][1] = int'(it.py);
        pos_m[slot][2] = int'(it.pz);
        vel_m[slot][0] = int'(it.vx);
        vel_m[slot][1] = int'(it.vy);
        vel_m[slot][2] = int'(it.vz);
        life_m[slot]   = {16'd0, it.life};
        start_m[slot]  = {16'd0, it.life};
        size_m[slot]   = {16'd0, it.size};
        color_m[slot]  = it.color;
        kind_m[slot]   = it.kind;
        live_mask[slot] = 1'b1;
        if (typed) begin
          r = '{rec: REC_ACK, slot: typed_slot, x: it.px, y: it.py, z: it.pz,
                size: it.size, color: it.color, kind: it.kind, last: 1'b1};
        end else begin
          r = slot_report(REC_ACK, slot, 1'b1);
        end
        pending_q.push_back(r);
      end
      FN_TICK: begin
        for (int i = 0; i < n_used; i++) begin
          if (live_mask[i]) begin
            age_slot(i, it.dt);
            if (live_mask[i]) pending_q.push_back(slot_report(REC_LIVE, i, 1'b0));
          end
        end
        r = '{rec: REC_END, slot: '0, x: '0, y: '0, z: '0, size: '0, color: '0,
              kind: '0, last: 1'b1};
        pending_q.push_back(r);
      end
      FN_CLEAR: begin
        live_mask = '0;
        n_used = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.func  = (pick < 60) ? FN_EMIT : (pick < 97) ? FN_TICK : (pick < 99) ? FN_CLEAR : FN_NONE;
    it.px    = 16'($urandom);
    it.py    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
    it.pz    = 16'($urandom);
    it.vx    = 16'($urandom);
    it.vy    = 16'($urandom);
    it.vz    = 16'($urandom);
    it.life  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(8192, 65535));
    it.size  = 16'($urandom);
    it.color = $urandom;
    it.kind  = 2'($urandom_range(0, 3));
    it.dt    = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1200));
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, logic [4:0] typed_slot);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid      = 1'b1;
    in_ch.func       = it.func;
    in_ch.pos_x      = it.px;
    in_ch.pos_y      = it.py;
    in_ch.pos_z      = it.pz;
    in_ch.vel_x      = it.vx;
    in_ch.vel_y      = it.vy;
    in_ch.vel_z      = it.vz;
    in_ch.lifetime   = it.life;
    in_ch.start_size = it.size;
    in_ch.color_rgba = it.color;
    in_ch.kind       = it.kind;
    in_ch.delta_time = it.dt;
    do @(posedge clk); while (!in_ch.ready);
    predict_pool(it, typed, typed_slot);
    @(negedge clk);
  endtask

  task automatic drain_pool();
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
    // a clear gives no item back, so allow the block to settle
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_floor(logic signed [15:0] v);
    cfg_ch.valid        = 1'b1;
    cfg_ch.floor_height = v;
    do @(posedge clk); while (!cfg_ch.ready);
    floor_m = int'(v);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_err++;
    end
  endtask

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off once traffic is flowing
  initial begin
    int hold;
    int phase;
    hold = 0;
    phase = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && n_seen >= 100 && phase == 0) begin
        hold = 600;
        phase = 1;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else if ((cyc / 64) % 3 == 0) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected item: record 0x%0h slot %0d", out_ch.record, out_ch.slot);
        n_err++;
      end else begin
        want = pending_q.pop_front();
        check_field("record", want.rec, out_ch.record);
        check_field("slot", want.slot, out_ch.slot);
        check_field("out_x", want.x, out_ch.out_x);
        check_field("out_y", want.y, out_ch.out_y);
        check_field("out_z", want.z, out_ch.out_z);
        check_field("out_size", want.size, out_ch.out_size);
        check_field("out_color", want.color, out_ch.out_color);
        check_field("out_kind", want.kind, out_ch.out_kind);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  initial begin
    logic signed [15:0] floors [5];
    n_err = 0;
    n_seen = 0;
    cyc = 0;
    burst_left = 0;
    live_mask = '0;
    n_used = 0;
    floor_m = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_NONE;
    {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.vel_x, in_ch.vel_y, in_ch.vel_z} = '0;
    {in_ch.lifetime, in_ch.start_size, in_ch.color_rgba, in_ch.kind, in_ch.delta_time} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.floor_height = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].ack_slot);
    end
    drain_pool();

    floors[0] = 16'sh0000;
    floors[1] = 16'sh7fff;
    floors[2] = 16'sh8000;
    floors[3] = 16'($urandom);
    floors[4] = 16'($urandom_range(0, 1024));
    for (int p = 0; p < 5; p++) begin
      write_floor(floors[p]);
      for (int k = 0; k < N_RAND; k++) begin
        send_item(random_item(), 1'b0, '0);
      end
      drain_pool();
    end

    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
